@@ hw/rtl/rs485_half_duplex_buffer_ctrl_top_assert.svh @@
// Assertion macros for the RS-485 buffer controller.
// Included by the top level; no other dependencies.
`ifndef RS485_HALF_DUPLEX_BUFFER_CTRL_TOP_ASSERT_SVH
`define RS485_HALF_DUPLEX_BUFFER_CTRL_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RHDBC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhdbc assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RHDBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rhdbc assertion failed");

`endif

@@ hw/rtl/rhdbc_pkg.sv @@
// Shared types and constants of the RS-485 buffer controller.
// No dependencies; used by the interfaces and every module.
package rhdbc_pkg;

   localparam int TX_DEPTH  = 256;
   localparam int RX_DEPTH  = 256;
   localparam int TX_PTR_W  = $clog2(TX_DEPTH);
   localparam int RX_IDX_W  = $clog2(RX_DEPTH);
   localparam int SIZE_W    = 9;
   localparam int BYTE_W    = 8;
   localparam int TIMER_W   = 16;
   localparam int REQ_W     = 4;
   localparam int CSR_IDX_W = 4;

   localparam logic [SIZE_W-1:0] TX_SIZE_MIN   = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] TX_SIZE_MAX   = SIZE_W'(TX_DEPTH);
   localparam logic [SIZE_W-1:0] RX_SIZE_MIN   = SIZE_W'(1);
   localparam logic [SIZE_W-1:0] RX_SIZE_MAX   = SIZE_W'(RX_DEPTH);
   localparam logic [SIZE_W-1:0] TX_SIZE_RESET = SIZE_W'(256);
   localparam logic [SIZE_W-1:0] RX_SIZE_RESET = SIZE_W'(256);

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH      = 4'd0,
      REQ_TX_EMPTY  = 4'd1,
      REQ_TX_DONE   = 4'd2,
      REQ_RX_BYTE   = 4'd3,
      REQ_TICK      = 4'd4,
      REQ_TIMEOUT   = 4'd5,
      REQ_RESTORE   = 4'd6,
      REQ_SET_TIMER = 4'd7,
      REQ_READ      = 4'd8
   } req_code_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TX_RING_SIZE     = 4'd0,
      CSR_RX_BUFFER_SIZE   = 4'd1,
      CSR_TXE_ACTIVE_LEVEL = 4'd2,
      CSR_TXE_IDLE_LEVEL   = 4'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } ctl_state_type;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [BYTE_W-1:0]  data_byte;
      logic [TIMER_W-1:0] timer_value;
      logic [RX_IDX_W-1:0] rx_index;
   } req_item_type;

   typedef struct packed {
      logic                push_accepted;
      logic                uart_tx_valid;
      logic [BYTE_W-1:0]   uart_tx_byte;
      logic                txe_pin;
      logic                tx_empty_irq_enable;
      logic                tx_complete_irq_enable;
      logic                tx_busy;
      logic                frame_complete;
      logic [RX_IDX_W-1:0] rx_fill;
      logic [BYTE_W-1:0]   read_data;
   } rsp_item_type;

   typedef struct packed {
      logic                 we;
      logic [CSR_IDX_W-1:0] index;
      logic [SIZE_W-1:0]    wdata;
   } csr_write_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic execute;
   } ctl_cmd_type;

endpackage

@@ hw/rtl/rhdbc_if.sv @@
// Channel interfaces of the RS-485 buffer controller: request, response, CSR write.
// Depends on rhdbc_pkg.
interface rhdbc_req_if;
   logic                          valid;
   logic                          ready;
   logic [rhdbc_pkg::REQ_W-1:0]   req_type;
   logic [rhdbc_pkg::BYTE_W-1:0]  data_byte;
   logic [rhdbc_pkg::TIMER_W-1:0] timer_value;
   logic [rhdbc_pkg::RX_IDX_W-1:0] rx_index;

   modport source (output valid, req_type, data_byte, timer_value, rx_index, input ready);
   modport sink (input valid, req_type, data_byte, timer_value, rx_index, output ready);
endinterface

interface rhdbc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           push_accepted;
   logic                           uart_tx_valid;
   logic [rhdbc_pkg::BYTE_W-1:0]   uart_tx_byte;
   logic                           txe_pin;
   logic                           tx_empty_irq_enable;
   logic                           tx_complete_irq_enable;
   logic                           tx_busy;
   logic                           frame_complete;
   logic [rhdbc_pkg::RX_IDX_W-1:0] rx_fill;
   logic [rhdbc_pkg::BYTE_W-1:0]   read_data;

   modport source (output valid, push_accepted, uart_tx_valid, uart_tx_byte, txe_pin,
                   tx_empty_irq_enable, tx_complete_irq_enable, tx_busy,
                   frame_complete, rx_fill, read_data, input ready);
   modport sink (input valid, push_accepted, uart_tx_valid, uart_tx_byte, txe_pin,
                 tx_empty_irq_enable, tx_complete_irq_enable, tx_busy,
                 frame_complete, rx_fill, read_data, output ready);
endinterface

interface rhdbc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rhdbc_pkg::CSR_IDX_W-1:0] index;
   logic [rhdbc_pkg::SIZE_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

@@ hw/rtl/rhdbc_ctrl.sv @@
// Request sequencer of the RS-485 buffer controller: accept, execute, respond.
// Depends on rhdbc_pkg.
module rhdbc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rhdbc_pkg::ctl_cmd_type cmd
);

   rhdbc_pkg::ctl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhdbc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         rhdbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rhdbc_pkg::ST_EXEC;
            end
         end
         rhdbc_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = rhdbc_pkg::ST_RESP;
         end
         rhdbc_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = rhdbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rhdbc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/rhdbc_dpath.sv @@
// Datapath of the RS-485 buffer controller: tx ring, rx store, timer, flags, CSRs.
// Depends on rhdbc_pkg; driven by rhdbc_ctrl commands.
module rhdbc_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  rhdbc_pkg::ctl_cmd_type  cmd,
   input  rhdbc_pkg::req_item_type req_item,
   input  rhdbc_pkg::csr_write_type csr_wr,
   output rhdbc_pkg::rsp_item_type rsp_item
);

   localparam int TXP = rhdbc_pkg::TX_PTR_W;
   localparam int RXI = rhdbc_pkg::RX_IDX_W;
   localparam int SW  = rhdbc_pkg::SIZE_W;
   localparam int BW  = rhdbc_pkg::BYTE_W;
   localparam int TW  = rhdbc_pkg::TIMER_W;

   // Limit a size register to the legal range
   function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
                                                input logic [SW-1:0] lo,
                                                input logic [SW-1:0] hi);
      logic [SW-1:0] r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r;
   endfunction

   // Configuration registers
   logic [SW-1:0] tx_size_ff, rx_size_ff;
   logic          txe_act_ff, txe_idle_ff;

   // Latched request
   rhdbc_pkg::req_item_type req_ff;

   // Memories
   logic [BW-1:0] tx_ring_mem [rhdbc_pkg::TX_DEPTH];
   logic [BW-1:0] rx_mem [rhdbc_pkg::RX_DEPTH];
   logic [BW-1:0] tx_rd_data_ff, rx_rd_data_ff;

   // Control state
   logic [TXP-1:0] tx_wr_ptr_ff, tx_wr_ptr_in;
   logic [TXP-1:0] tx_rd_ptr_ff, tx_rd_ptr_in;
   logic           tx_active_ff, tx_active_in;
   logic           txe_level_ff, txe_level_in;
   logic           txe_int_en_ff, txe_int_en_in;
   logic           tc_int_en_ff, tc_int_en_in;
   logic [rhdbc_pkg::RX_DEPTH-1:0] rx_valid_ff, rx_valid_in;
   logic [RXI-1:0] rx_wr_idx_ff, rx_wr_idx_in;
   logic [TW-1:0]  timer_ff, timer_in;
   logic           rx_done_ff, rx_done_in;

   // Per-request result flags
   logic push_ok_ff, push_ok_in;
   logic txv_ff, txv_in;
   logic rd_hit_ff, rd_hit_in;

   // Decode helpers
   logic [SW-1:0]  tx_size_eff, rx_size_eff;
   logic [SW-1:0]  tx_wr_inc, tx_rd_inc, rx_idx_inc;
   logic [TXP-1:0] tx_wr_next, tx_rd_next;
   logic [RXI-1:0] rx_idx_next;
   logic           tx_full, tx_empty;
   logic           is_push, is_tx_empty, is_rx_byte;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_size_ff  <= rhdbc_pkg::TX_SIZE_RESET;
         rx_size_ff  <= rhdbc_pkg::RX_SIZE_RESET;
         txe_act_ff  <= 1'b1;
         txe_idle_ff <= 1'b0;
      end else if (csr_wr.we) begin
         unique case (csr_wr.index)
            rhdbc_pkg::CSR_TX_RING_SIZE:     tx_size_ff  <= csr_wr.wdata;
            rhdbc_pkg::CSR_RX_BUFFER_SIZE:   rx_size_ff  <= csr_wr.wdata;
            rhdbc_pkg::CSR_TXE_ACTIVE_LEVEL: txe_act_ff  <= csr_wr.wdata[0];
            rhdbc_pkg::CSR_TXE_IDLE_LEVEL:   txe_idle_ff <= csr_wr.wdata[0];
            default: ;
         endcase
      end
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
   end

   // Pointer arithmetic with wrap at the active size
   always_comb begin
      tx_size_eff = clamp_size(tx_size_ff, rhdbc_pkg::TX_SIZE_MIN, rhdbc_pkg::TX_SIZE_MAX);
      rx_size_eff = clamp_size(rx_size_ff, rhdbc_pkg::RX_SIZE_MIN, rhdbc_pkg::RX_SIZE_MAX);
      tx_wr_inc   = SW'(tx_wr_ptr_ff) + SW'(1);
      tx_rd_inc   = SW'(tx_rd_ptr_ff) + SW'(1);
      rx_idx_inc  = SW'(rx_wr_idx_ff) + SW'(1);
      tx_wr_next  = (tx_wr_inc >= tx_size_eff) ? '0 : tx_wr_inc[TXP-1:0];
      tx_rd_next  = (tx_rd_inc >= tx_size_eff) ? '0 : tx_rd_inc[TXP-1:0];
      rx_idx_next = (rx_idx_inc >= rx_size_eff) ? '0 : rx_idx_inc[RXI-1:0];
      tx_full     = (tx_wr_next == tx_rd_ptr_ff);
      tx_empty    = (tx_rd_ptr_ff == tx_wr_ptr_ff);
      is_push     = cmd.execute && (req_ff.req_type == rhdbc_pkg::REQ_PUSH);
      is_tx_empty = cmd.execute && (req_ff.req_type == rhdbc_pkg::REQ_TX_EMPTY);
      is_rx_byte  = cmd.execute && (req_ff.req_type == rhdbc_pkg::REQ_RX_BYTE);
   end

   // Event decode
   always_comb begin
      tx_wr_ptr_in  = tx_wr_ptr_ff;
      tx_rd_ptr_in  = tx_rd_ptr_ff;
      tx_active_in  = tx_active_ff;
      txe_level_in  = txe_level_ff;
      txe_int_en_in = txe_int_en_ff;
      tc_int_en_in  = tc_int_en_ff;
      rx_valid_in   = rx_valid_ff;
      rx_wr_idx_in  = rx_wr_idx_ff;
      timer_in      = timer_ff;
      rx_done_in    = rx_done_ff;
      push_ok_in    = push_ok_ff;
      txv_in        = txv_ff;
      rd_hit_in     = rd_hit_ff;
      if (cmd.execute) begin
         push_ok_in = 1'b0;
         txv_in     = 1'b0;
         rd_hit_in  = 1'b0;
         unique case (req_ff.req_type)
            rhdbc_pkg::REQ_PUSH: begin
               if (!tx_full) begin
                  tx_wr_ptr_in = tx_wr_next;
                  push_ok_in   = 1'b1;
                  if (!tx_active_ff) begin
                     txe_level_in  = txe_act_ff;
                     tx_active_in  = 1'b1;
                     txe_int_en_in = 1'b1;
                     tc_int_en_in  = 1'b1;
                  end
               end
            end
            rhdbc_pkg::REQ_TX_EMPTY: begin
               if (!tx_empty) begin
                  txv_in       = 1'b1;
                  tx_rd_ptr_in = tx_rd_next;
                  tx_active_in = 1'b1;
               end else begin
                  tx_active_in  = 1'b0;
                  txe_int_en_in = 1'b0;
               end
            end
            rhdbc_pkg::REQ_TX_DONE: begin
               if (tx_empty) begin
                  txe_level_in = txe_idle_ff;
               end
            end
            rhdbc_pkg::REQ_RX_BYTE: begin
               rx_done_in                = 1'b0;
               rx_valid_in[rx_wr_idx_ff] = 1'b1;
               rx_wr_idx_in              = rx_idx_next;
            end
            rhdbc_pkg::REQ_TICK: begin
               if (timer_ff != '0) begin
                  timer_in = timer_ff - TW'(1);
                  if (timer_ff == TW'(1)) begin
                     rx_done_in = 1'b1;
                  end
               end
            end
            rhdbc_pkg::REQ_TIMEOUT: begin
               rx_done_in = 1'b1;
            end
            rhdbc_pkg::REQ_RESTORE: begin
               // drop every entry below the current write index
               for (int i = 0; i < rhdbc_pkg::RX_DEPTH; i++) begin
                  if (RXI'(i) < rx_wr_idx_ff) begin
                     rx_valid_in[i] = 1'b0;
                  end
               end
               rx_wr_idx_in = '0;
               rx_done_in   = 1'b0;
            end
            rhdbc_pkg::REQ_SET_TIMER: begin
               timer_in = req_ff.timer_value;
            end
            rhdbc_pkg::REQ_READ: begin
               rd_hit_in = rx_valid_ff[req_ff.rx_index];
            end
            default: ;
         endcase
      end
   end

   // Control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wr_ptr_ff  <= '0;
         tx_rd_ptr_ff  <= '0;
         tx_active_ff  <= 1'b0;
         txe_level_ff  <= 1'b0;
         txe_int_en_ff <= 1'b0;
         tc_int_en_ff  <= 1'b0;
         rx_valid_ff   <= '0;
         rx_wr_idx_ff  <= '0;
         timer_ff      <= '0;
         rx_done_ff    <= 1'b0;
         push_ok_ff    <= 1'b0;
         txv_ff        <= 1'b0;
         rd_hit_ff     <= 1'b0;
      end else begin
         tx_wr_ptr_ff  <= tx_wr_ptr_in;
         tx_rd_ptr_ff  <= tx_rd_ptr_in;
         tx_active_ff  <= tx_active_in;
         txe_level_ff  <= txe_level_in;
         txe_int_en_ff <= txe_int_en_in;
         tc_int_en_ff  <= tc_int_en_in;
         rx_valid_ff   <= rx_valid_in;
         rx_wr_idx_ff  <= rx_wr_idx_in;
         timer_ff      <= timer_in;
         rx_done_ff    <= rx_done_in;
         push_ok_ff    <= push_ok_in;
         txv_ff        <= txv_in;
         rd_hit_ff     <= rd_hit_in;
      end
   end

   // Transmit ring: one write port, registered read
   always_ff @(posedge clock) begin
      if (is_push && !tx_full) begin
         tx_ring_mem[tx_wr_ptr_ff] <= req_ff.data_byte;
      end
      if (is_tx_empty) begin
         tx_rd_data_ff <= tx_ring_mem[tx_rd_ptr_ff];
      end
   end

   // Receive store: one write port, registered read
   always_ff @(posedge clock) begin
      if (is_rx_byte) begin
         rx_mem[rx_wr_idx_ff] <= req_ff.data_byte;
      end
      if (cmd.execute) begin
         rx_rd_data_ff <= rx_mem[req_ff.rx_index];
      end
   end

   // Response fields, all from registers that hold until the next request
   always_comb begin
      rsp_item.push_accepted          = push_ok_ff;
      rsp_item.uart_tx_valid          = txv_ff;
      rsp_item.uart_tx_byte           = txv_ff ? tx_rd_data_ff : '0;
      rsp_item.txe_pin                = txe_level_ff;
      rsp_item.tx_empty_irq_enable    = txe_int_en_ff;
      rsp_item.tx_complete_irq_enable = tc_int_en_ff;
      rsp_item.tx_busy                = tx_active_ff;
      rsp_item.frame_complete         = rx_done_ff;
      rsp_item.rx_fill                = rx_wr_idx_ff;
      rsp_item.read_data              = rd_hit_ff ? rx_rd_data_ff : '0;
   end

endmodule

@@ hw/rtl/rs485_half_duplex_buffer_ctrl_top.sv @@
// Half-duplex RS-485 buffer controller. Each request is one event (push, tx empty,
// tx complete, rx byte, tick, timeout, restore, set timer, read) and yields exactly
// one response carrying the flags after the event. A request is accepted in ST_IDLE,
// executed in ST_EXEC against the tx ring and rx store (both memories with a
// registered read port) and presented as a response in ST_RESP, where it waits
// for rsp_ch.ready; the next request is taken once the response is delivered.
// Receive valid bits are flip-flops cleared by reset, so no clearing
// pass is needed after reset. CSR writes are taken in any cycle.
// Depends on rhdbc_pkg, rhdbc_if, rhdbc_ctrl, rhdbc_dpath and the assertion header.
`include "rs485_half_duplex_buffer_ctrl_top_assert.svh"

module rs485_half_duplex_buffer_ctrl_top (
   input logic        clock,
   input logic        reset,
   rhdbc_req_if.sink  req_ch,
   rhdbc_rsp_if.source rsp_ch,
   rhdbc_csr_if.sink  csr_ch
);

   rhdbc_pkg::ctl_cmd_type   cmd;
   rhdbc_pkg::req_item_type  req_item;
   rhdbc_pkg::rsp_item_type  rsp_item;
   rhdbc_pkg::csr_write_type csr_wr;

   // Channel packing
   assign csr_ch.ready         = 1'b1;
   assign csr_wr.we            = csr_ch.valid;
   assign csr_wr.index         = csr_ch.index;
   assign csr_wr.wdata         = csr_ch.wdata;
   assign req_item.req_type    = req_ch.req_type;
   assign req_item.data_byte   = req_ch.data_byte;
   assign req_item.timer_value = req_ch.timer_value;
   assign req_item.rx_index    = req_ch.rx_index;

   assign rsp_ch.push_accepted          = rsp_item.push_accepted;
   assign rsp_ch.uart_tx_valid          = rsp_item.uart_tx_valid;
   assign rsp_ch.uart_tx_byte           = rsp_item.uart_tx_byte;
   assign rsp_ch.txe_pin                = rsp_item.txe_pin;
   assign rsp_ch.tx_empty_irq_enable    = rsp_item.tx_empty_irq_enable;
   assign rsp_ch.tx_complete_irq_enable = rsp_item.tx_complete_irq_enable;
   assign rsp_ch.tx_busy                = rsp_item.tx_busy;
   assign rsp_ch.frame_complete         = rsp_item.frame_complete;
   assign rsp_ch.rx_fill                = rsp_item.rx_fill;
   assign rsp_ch.read_data              = rsp_item.read_data;

   // Sequencer
   rhdbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // Storage and event logic
   rhdbc_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .csr_wr   (csr_wr),
      .rsp_item (rsp_item)
   );

   // Checks
   `RHDBC_ASSERT_SAME(a_one_in_flight, clock, reset, rsp_ch.valid, !req_ch.ready)
   `RHDBC_ASSERT_NEXT(a_exec_after_accept, clock, reset, req_ch.valid && req_ch.ready, cmd.execute && !rsp_ch.valid)
   `RHDBC_ASSERT_SAME(a_push_sets_busy, clock, reset, rsp_ch.valid && rsp_ch.push_accepted, rsp_ch.tx_busy)
   `RHDBC_ASSERT_SAME(a_send_sets_busy, clock, reset, rsp_ch.valid && rsp_ch.uart_tx_valid, rsp_ch.tx_busy && rsp_ch.tx_complete_irq_enable)

endmodule

@@ tb/rs485_half_duplex_buffer_ctrl_top_test.sv @@
// Self-checking testbench for the RS-485 half-duplex buffer controller top level.
// Drives event requests and CSR writes and checks every response against an in-bench predictor.
// Depends on rhdbc_pkg, the rhdbc channel interfaces and rs485_half_duplex_buffer_ctrl_top.
module rs485_half_duplex_buffer_ctrl_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int REQ_CODE_LAST  = (1 << rhdbc_pkg::REQ_W) - 1;
   localparam int PRINT_LIMIT    = 100;
   localparam int MIXED_BUDGET   = 95;

   logic clock;
   logic reset;

   rhdbc_req_if req_ch ();
   rhdbc_rsp_if rsp_ch ();
   rhdbc_csr_if csr_ch ();

   rs485_half_duplex_buffer_ctrl_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Idle profile, changed per phase
   int req_gap_pct   = 6;
   int rsp_stall_pct = 46;

   // Bookkeeping
   int sent_count     = 0;
   int checked_count  = 0;
   int csr_count      = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   rhdbc_pkg::rsp_item_type status_due[$];

   // Predictor copy of the configuration
   int tx_size_cfg = 256;
   int rx_size_cfg = 256;
   bit level_on    = 1'b1;
   bit level_off   = 1'b0;

   // Predictor copy of the block state
   logic [rhdbc_pkg::BYTE_W-1:0] ring_mem [rhdbc_pkg::TX_DEPTH];
   int                tx_wr      = 0;
   int                tx_rd      = 0;
   bit                sending    = 1'b0;
   bit                pin_q      = 1'b0;
   bit                empty_ie_q = 1'b0;
   bit                done_ie_q  = 1'b0;
   logic [rhdbc_pkg::BYTE_W-1:0] rx_mem [rhdbc_pkg::RX_DEPTH];
   bit                rx_vld [rhdbc_pkg::RX_DEPTH];
   int                rx_wr      = 0;
   int                idle_cnt   = 0;
   bit                frame_done = 1'b0;

   // Receive entries written at least once since reset; reads only target these
   bit rx_seen [rhdbc_pkg::RX_DEPTH];
   int rx_written_list[$];

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Cycle limit guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Response back-pressure
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int ring_span();
      return clamp_int(tx_size_cfg, int'(rhdbc_pkg::TX_SIZE_MIN), rhdbc_pkg::TX_DEPTH);
   endfunction

   function automatic int ring_next(input int p);
      int n;
      n = p + 1;
      if (n >= ring_span()) n = 0;
      return n;
   endfunction

   function automatic logic [rhdbc_pkg::BYTE_W-1:0] rand_byte();
      return rhdbc_pkg::BYTE_W'($urandom);
   endfunction

   function automatic logic [rhdbc_pkg::TIMER_W-1:0] rand_timer();
      return rhdbc_pkg::TIMER_W'($urandom);
   endfunction

   function automatic logic [rhdbc_pkg::RX_IDX_W-1:0] rand_index();
      return rhdbc_pkg::RX_IDX_W'($urandom);
   endfunction

   // Pick a receive entry that has been written; -1 when none has
   function automatic int pick_read_index();
      int idx;
      if (rx_written_list.size() == 0) return -1;
      idx = $urandom_range(rhdbc_pkg::RX_DEPTH - 1);
      if (rx_seen[idx]) return idx;
      return rx_written_list[$urandom_range(rx_written_list.size() - 1)];
   endfunction

   // Apply one event to the predicted state and return the status it yields
   function automatic rhdbc_pkg::rsp_item_type apply_event(input rhdbc_pkg::req_item_type r);
      rhdbc_pkg::rsp_item_type o;
      int           nxt;
      o = '0;
      case (r.req_type)
         rhdbc_pkg::REQ_PUSH: begin
            nxt = ring_next(tx_wr);
            if (nxt != tx_rd) begin
               ring_mem[tx_wr] = r.data_byte;
               tx_wr = nxt;
               o.push_accepted = 1'b1;
               if (!sending) begin
                  pin_q      = level_on;
                  sending    = 1'b1;
                  empty_ie_q = 1'b1;
                  done_ie_q  = 1'b1;
               end
            end
         end
         rhdbc_pkg::REQ_TX_EMPTY: begin
            if (tx_rd != tx_wr) begin
               o.uart_tx_valid = 1'b1;
               o.uart_tx_byte  = ring_mem[tx_rd];
               tx_rd   = ring_next(tx_rd);
               sending = 1'b1;
            end else begin
               sending    = 1'b0;
               empty_ie_q = 1'b0;
            end
         end
         rhdbc_pkg::REQ_TX_DONE: begin
            if (tx_rd == tx_wr) pin_q = level_off;
         end
         rhdbc_pkg::REQ_RX_BYTE: begin
            frame_done     = 1'b0;
            rx_mem[rx_wr]  = r.data_byte;
            rx_vld[rx_wr]  = 1'b1;
            if (!rx_seen[rx_wr]) begin
               rx_seen[rx_wr] = 1'b1;
               rx_written_list.push_back(rx_wr);
            end
            rx_wr++;
            if (rx_wr >= clamp_int(rx_size_cfg, int'(rhdbc_pkg::RX_SIZE_MIN),
                                   rhdbc_pkg::RX_DEPTH))
               rx_wr = 0;
         end
         rhdbc_pkg::REQ_TICK: begin
            if (idle_cnt != 0) begin
               idle_cnt--;
               if (idle_cnt == 0) frame_done = 1'b1;
            end
         end
         rhdbc_pkg::REQ_TIMEOUT: frame_done = 1'b1;
         rhdbc_pkg::REQ_RESTORE: begin
            for (int i = 0; i < rx_wr; i++) begin
               rx_mem[i] = '0;
               rx_vld[i] = 1'b0;
            end
            rx_wr      = 0;
            frame_done = 1'b0;
         end
         rhdbc_pkg::REQ_SET_TIMER: idle_cnt = int'(r.timer_value);
         rhdbc_pkg::REQ_READ: begin
            if (rx_vld[r.rx_index]) o.read_data = rx_mem[r.rx_index];
         end
         default: ;
      endcase
      o.txe_pin                = pin_q;
      o.tx_empty_irq_enable    = empty_ie_q;
      o.tx_complete_irq_enable = done_ie_q;
      o.tx_busy                = sending;
      o.frame_complete         = frame_done;
      o.rx_fill                = rhdbc_pkg::RX_IDX_W'(rx_wr);
      return o;
   endfunction

   task automatic note_mismatch(input string what, input logic [15:0] got,
                                input logic [15:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Send one request; returns at a falling edge with valid still high
   task automatic issue(input logic [rhdbc_pkg::REQ_W-1:0] code,
                        input logic [rhdbc_pkg::BYTE_W-1:0] b,
                        input logic [rhdbc_pkg::TIMER_W-1:0] t,
                        input logic [rhdbc_pkg::RX_IDX_W-1:0] idx);
      rhdbc_pkg::req_item_type taken;
      if ($urandom_range(99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < req_gap_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= code;
      req_ch.data_byte   <= b;
      req_ch.timer_value <= t;
      req_ch.rx_index    <= idx;
      do @(posedge clock); while (!req_ch.ready);
      taken.req_type    = req_ch.req_type;
      taken.data_byte   = req_ch.data_byte;
      taken.timer_value = req_ch.timer_value;
      taken.rx_index    = req_ch.rx_index;
      status_due.push_back(apply_event(taken));
      sent_count++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every response is back and the pipe is empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (status_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input rhdbc_pkg::csr_idx_type idx,
                            input logic [rhdbc_pkg::SIZE_W-1:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= v;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         rhdbc_pkg::CSR_TX_RING_SIZE:     tx_size_cfg = int'(v);
         rhdbc_pkg::CSR_RX_BUFFER_SIZE:   rx_size_cfg = int'(v);
         rhdbc_pkg::CSR_TXE_ACTIVE_LEVEL: level_on    = v[0];
         rhdbc_pkg::CSR_TXE_IDLE_LEVEL:   level_off   = v[0];
         default: ;
      endcase
      csr_count++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Empty the transmit ring, then release the driver
   task automatic drain_tx_ring();
      while (tx_rd != tx_wr)
         issue(rhdbc_pkg::REQ_TX_EMPTY, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TX_DONE, rand_byte(), rand_timer(), rand_index());
   endtask

   // Ring size changes only with an empty ring, so no stale slot is ever handed out
   task automatic set_config(input int tx_size, input int rx_size, input bit on, input bit off);
      drain_tx_ring();
      settle();
      write_csr(rhdbc_pkg::CSR_TX_RING_SIZE, rhdbc_pkg::SIZE_W'(tx_size));
      write_csr(rhdbc_pkg::CSR_RX_BUFFER_SIZE, rhdbc_pkg::SIZE_W'(rx_size));
      write_csr(rhdbc_pkg::CSR_TXE_ACTIVE_LEVEL, rhdbc_pkg::SIZE_W'(on));
      write_csr(rhdbc_pkg::CSR_TXE_IDLE_LEVEL, rhdbc_pkg::SIZE_W'(off));
   endtask

   // Events right after reset: complete with empty ring, tick at zero, unknown code
   task automatic test_idle_events();
      issue(rhdbc_pkg::REQ_TX_DONE, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TICK, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_W'(REQ_CODE_LAST), 8'hFF, 16'hFFFF, 8'hFF);
   endtask

   // Byte extremes through the ring, then a tx empty event on an empty ring
   task automatic test_tx_handoff();
      issue(rhdbc_pkg::REQ_PUSH, 8'h00, rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_PUSH, 8'hFF, rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TX_EMPTY, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TX_EMPTY, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TX_EMPTY, rand_byte(), rand_timer(), rand_index());
   endtask

   // Minimum ring with inverted pin levels; pointers start outside the shrunk ring
   task automatic test_ring_full();
      set_config(int'(rhdbc_pkg::TX_SIZE_MIN), 256, 1'b0, 1'b1);
      issue(rhdbc_pkg::REQ_PUSH, 8'h5A, rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_PUSH, 8'hA5, rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TX_DONE, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TX_EMPTY, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TX_EMPTY, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_PUSH, 8'h3C, rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_PUSH, 8'hC3, rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TX_EMPTY, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TX_EMPTY, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TX_DONE, rand_byte(), rand_timer(), rand_index());
   endtask

   // Receive frame: idle timer expiry, read, forced timeout, restore, read of cleared entry
   task automatic test_rx_frame();
      issue(rhdbc_pkg::REQ_SET_TIMER, rand_byte(), 16'd2, rand_index());
      issue(rhdbc_pkg::REQ_RX_BYTE, 8'hA5, rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TICK, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_TICK, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_READ, rand_byte(), rand_timer(), '0);
      issue(rhdbc_pkg::REQ_TIMEOUT, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_RESTORE, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_READ, rand_byte(), rand_timer(), '0);
   endtask

   // Fill the whole receive buffer and wrap, reading back along the way
   task automatic test_rx_wrap();
      int idx;
      repeat (rhdbc_pkg::RX_DEPTH + 4) begin
         issue(rhdbc_pkg::REQ_RX_BYTE, rand_byte(), rand_timer(), rand_index());
         if ($urandom_range(15) == 0) begin
            idx = pick_read_index();
            issue(rhdbc_pkg::REQ_READ, rand_byte(), rand_timer(),
                  rhdbc_pkg::RX_IDX_W'(idx));
         end
      end
      issue(rhdbc_pkg::REQ_READ, rand_byte(), rand_timer(),
            rhdbc_pkg::RX_IDX_W'(rhdbc_pkg::RX_DEPTH - 1));
      issue(rhdbc_pkg::REQ_READ, rand_byte(), rand_timer(),
            rhdbc_pkg::RX_IDX_W'(rhdbc_pkg::RX_DEPTH / 2));
      issue(rhdbc_pkg::REQ_RESTORE, rand_byte(), rand_timer(), rand_index());
      issue(rhdbc_pkg::REQ_READ, rand_byte(), rand_timer(), rhdbc_pkg::RX_IDX_W'(2));
      issue(rhdbc_pkg::REQ_READ, rand_byte(), rand_timer(),
            rhdbc_pkg::RX_IDX_W'(rhdbc_pkg::RX_DEPTH - 1));
   endtask

   // Mostly well-formed transmit bursts and receive frames, the rest single random events
   task automatic run_mixed_traffic(input int budget);
      int stop_at, pick, n, tv, idx;
      logic [rhdbc_pkg::REQ_W-1:0] code;
      stop_at = sent_count + budget;
      while (sent_count < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            // burst may overfill a small ring
            n = $urandom_range(1, (ring_span() < 8) ? ring_span() + 1 : 8);
            repeat (n) issue(rhdbc_pkg::REQ_PUSH, rand_byte(), rand_timer(), rand_index());
            if ($urandom_range(3) == 0)
               issue(rhdbc_pkg::REQ_TX_DONE, rand_byte(), rand_timer(), rand_index());
            while (tx_rd != tx_wr) begin
               issue(rhdbc_pkg::REQ_TX_EMPTY, rand_byte(), rand_timer(), rand_index());
               if ($urandom_range(4) == 0)
                  issue(rhdbc_pkg::REQ_PUSH, rand_byte(), rand_timer(), rand_index());
            end
            issue(rhdbc_pkg::REQ_TX_EMPTY, rand_byte(), rand_timer(), rand_index());
            issue(rhdbc_pkg::REQ_TX_DONE, rand_byte(), rand_timer(), rand_index());
         end else if (pick < 75) begin
            // receive frame closed by the idle timer or a forced timeout
            tv = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(6);
            issue(rhdbc_pkg::REQ_SET_TIMER, rand_byte(), rhdbc_pkg::TIMER_W'(tv),
                  rand_index());
            repeat ($urandom_range(1, 6))
               issue(rhdbc_pkg::REQ_RX_BYTE, rand_byte(), rand_timer(), rand_index());
            if ($urandom_range(4) == 0)
               issue(rhdbc_pkg::REQ_TIMEOUT, rand_byte(), rand_timer(), rand_index());
            else
               repeat (((tv < 8) ? tv : 8) + $urandom_range(1))
                  issue(rhdbc_pkg::REQ_TICK, rand_byte(), rand_timer(), rand_index());
            repeat ($urandom_range(1, 3)) begin
               idx = pick_read_index();
               if (idx >= 0)
                  issue(rhdbc_pkg::REQ_READ, rand_byte(), rand_timer(),
                        rhdbc_pkg::RX_IDX_W'(idx));
            end
            if ($urandom_range(3) == 0)
               issue(rhdbc_pkg::REQ_RESTORE, rand_byte(), rand_timer(), rand_index());
         end else begin
            // any code, unknown ones included
            code = rhdbc_pkg::REQ_W'($urandom_range(REQ_CODE_LAST));
            idx  = int'(rand_index());
            if (code == rhdbc_pkg::REQ_READ) begin
               idx = pick_read_index();
               if (idx < 0) code = rhdbc_pkg::REQ_TIMEOUT;
            end
            issue(code, rand_byte(), rand_timer(), rhdbc_pkg::RX_IDX_W'(idx));
         end
      end
   endtask

   // Response checker
   always @(posedge clock) begin : check_rsp
      rhdbc_pkg::rsp_item_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.push_accepted          = rsp_ch.push_accepted;
         got.uart_tx_valid          = rsp_ch.uart_tx_valid;
         got.uart_tx_byte           = rsp_ch.uart_tx_byte;
         got.txe_pin                = rsp_ch.txe_pin;
         got.tx_empty_irq_enable    = rsp_ch.tx_empty_irq_enable;
         got.tx_complete_irq_enable = rsp_ch.tx_complete_irq_enable;
         got.tx_busy                = rsp_ch.tx_busy;
         got.frame_complete         = rsp_ch.frame_complete;
         got.rx_fill                = rsp_ch.rx_fill;
         got.read_data              = rsp_ch.read_data;
         if (status_due.size() == 0) begin
            note_mismatch("response with no request pending", '0, '0);
         end else begin
            want = status_due.pop_front();
            checked_count++;
            if (got.push_accepted !== want.push_accepted)
               note_mismatch("push_accepted", 16'(got.push_accepted), 16'(want.push_accepted));
            if (got.uart_tx_valid !== want.uart_tx_valid)
               note_mismatch("uart_tx_valid", 16'(got.uart_tx_valid), 16'(want.uart_tx_valid));
            if (got.uart_tx_byte !== want.uart_tx_byte)
               note_mismatch("uart_tx_byte", 16'(got.uart_tx_byte), 16'(want.uart_tx_byte));
            if (got.txe_pin !== want.txe_pin)
               note_mismatch("txe_pin", 16'(got.txe_pin), 16'(want.txe_pin));
            if (got.tx_empty_irq_enable !== want.tx_empty_irq_enable)
               note_mismatch("tx_empty_irq_enable", 16'(got.tx_empty_irq_enable),
                             16'(want.tx_empty_irq_enable));
            if (got.tx_complete_irq_enable !== want.tx_complete_irq_enable)
               note_mismatch("tx_complete_irq_enable", 16'(got.tx_complete_irq_enable),
                             16'(want.tx_complete_irq_enable));
            if (got.tx_busy !== want.tx_busy)
               note_mismatch("tx_busy", 16'(got.tx_busy), 16'(want.tx_busy));
            if (got.frame_complete !== want.frame_complete)
               note_mismatch("frame_complete", 16'(got.frame_complete), 16'(want.frame_complete));
            if (got.rx_fill !== want.rx_fill)
               note_mismatch("rx_fill", 16'(got.rx_fill), 16'(want.rx_fill));
            if (got.read_data !== want.read_data)
               note_mismatch("read_data", 16'(got.read_data), 16'(want.read_data));
         end
      end
   end

   // Test sequence
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = '0;
      req_ch.data_byte   = '0;
      req_ch.timer_value = '0;
      req_ch.rx_index    = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.wdata       = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender mostly busy, receiver stalls often
      req_gap_pct   = 6;
      rsp_stall_pct = 46;
      test_idle_events();
      test_tx_handoff();
      test_ring_full();
      test_rx_frame();
      test_rx_wrap();
      set_config(0, 1, 1'b0, 1'b1);
      run_mixed_traffic(MIXED_BUDGET);
      set_config(511, 511, 1'b1, 1'b0);
      run_mixed_traffic(MIXED_BUDGET);

      // sender gaps often, receiver mostly ready
      req_gap_pct   = 46;
      rsp_stall_pct = 6;
      set_config(5, 7, 1'b1, 1'b1);
      run_mixed_traffic(MIXED_BUDGET);
      set_config(3, 300, 1'b0, 1'b0);
      run_mixed_traffic(MIXED_BUDGET);

      // back to back in both directions
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      set_config($urandom_range(511), $urandom_range(511), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
      run_mixed_traffic(MIXED_BUDGET);
      set_config(256, 256, 1'b1, 1'b0);
      run_mixed_traffic(MIXED_BUDGET);

      settle();
      repeat (8) @(negedge clock);

      $display("Covered %0d event requests and %0d checked responses over %0d CSR writes,",
               sent_count, checked_count, csr_count);
      $display("three idle profiles and ring/buffer sizes from minimum to maximum; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/rhdbc_pkg.sv
hw/rtl/rhdbc_if.sv
hw/rtl/rhdbc_ctrl.sv
hw/rtl/rhdbc_dpath.sv
hw/rtl/rs485_half_duplex_buffer_ctrl_top.sv
tb/rs485_half_duplex_buffer_ctrl_top_test.sv
